// ----- src/fdsm_pkg.sv -----
package fdsm_pkg;

   // Field widths of one word on each channel
   localparam int unsigned OPCODE_W = 3;
   localparam int unsigned CELL_W   = 32;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned DEPTH_W  = 7;

   // Opcodes
   localparam logic [OPCODE_W-1:0] OP_PUSH = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_DROP = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_SWAP = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_OVER = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_DUP  = 3'd4;
   localparam logic [OPCODE_W-1:0] OP_NIP  = 3'd5;
   localparam logic [OPCODE_W-1:0] OP_ROT  = 3'd6;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_UNDER = 2'd1;
   localparam logic [STATUS_W-1:0] ST_OVER  = 2'd2;

   typedef struct packed {
      logic        [OPCODE_W-1:0] opcode;
      logic signed [CELL_W-1:0]   push_value;
   } req_word_type;

   typedef struct packed {
      logic        [STATUS_W-1:0] status;
      logic signed [CELL_W-1:0]   top_cell;
      logic        [DEPTH_W-1:0]  stack_depth;
   } rsp_word_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;    // capture the request word and read the third cell
      logic commit;  // execute the operation and load the response word
   } cmd_type;

endpackage

// ----- src/fdsm_stream_if.sv -----
interface fdsm_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- src/fdsm_ctrl.sv -----
module fdsm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output fdsm_pkg::cmd_type cmd
);

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;

   // Accept in idle; commit once the response register is free or being drained
   always_comb begin
      req_ready  = (state_ff == S_IDLE);
      cmd.load   = (state_ff == S_IDLE) && req_valid;
      cmd.commit = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_ready);
   end

   assign rsp_valid = rsp_valid_ff;

   // Hold state and the response valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_EXEC;
               end
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
               end
            end
            S_EXEC: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  state_ff     <= S_IDLE;
                  rsp_valid_ff <= 1'b1;
               end
            end
            default: begin
               state_ff     <= S_IDLE;
               rsp_valid_ff <= 1'b0;
            end
         endcase
      end
   end

endmodule

// ----- src/fdsm_datapath.sv -----
module fdsm_datapath #(
   parameter int unsigned STACK_CELLS = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  fdsm_pkg::cmd_type      cmd,
   input  fdsm_pkg::req_word_type req_word,
   output fdsm_pkg::rsp_word_type rsp_word
);

   localparam int unsigned AW = $clog2(STACK_CELLS);
   localparam int unsigned DW = $clog2(STACK_CELLS + 1);
   localparam int unsigned CW = fdsm_pkg::CELL_W;

   // Top two cells live in registers, the rest in the memory (bottom at 0)
   logic [CW-1:0]                 mem [STACK_CELLS];
   logic [DW-1:0]                 depth_ff, depth_in;
   logic [CW-1:0]                 tos_ff, tos_in;
   logic [CW-1:0]                 nos_ff, nos_in;
   logic [CW-1:0]                 rd_ff;
   logic [fdsm_pkg::OPCODE_W-1:0] op_ff;
   logic [CW-1:0]                 val_ff;
   fdsm_pkg::rsp_word_type        rsp_ff, rsp_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;
   logic [DW-1:0] need;
   logic          grow;
   logic          nop;
   logic          under;
   logic          over;

   // Third cell from the top sits at depth - 3
   assign rd_addr = AW'(depth_ff - DW'(3));

   // Decode the operation and work out the next stack state
   always_comb begin
      need     = '0;
      grow     = 1'b0;
      nop      = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = AW'(depth_ff - DW'(2));
      depth_in = depth_ff;
      tos_in   = tos_ff;
      nos_in   = nos_ff;

      case (op_ff)
         fdsm_pkg::OP_PUSH: grow = 1'b1;
         fdsm_pkg::OP_DROP: need = DW'(1);
         fdsm_pkg::OP_SWAP: need = DW'(2);
         fdsm_pkg::OP_OVER: begin
            need = DW'(2);
            grow = 1'b1;
         end
         fdsm_pkg::OP_DUP: begin
            need = DW'(1);
            grow = 1'b1;
         end
         fdsm_pkg::OP_NIP:  need = DW'(2);
         fdsm_pkg::OP_ROT:  need = DW'(3);
         default:           nop  = 1'b1;
      endcase

      under = !nop && (depth_ff < need);
      over  = !nop && !under && grow && (depth_ff >= DW'(STACK_CELLS));

      if (under) begin
         depth_in = '0;
      end else if (!nop && !over) begin
         case (op_ff)
            fdsm_pkg::OP_PUSH: begin
               wr_en    = (depth_ff >= DW'(2));
               nos_in   = tos_ff;
               tos_in   = val_ff;
               depth_in = depth_ff + DW'(1);
            end
            fdsm_pkg::OP_DROP: begin
               tos_in   = nos_ff;
               nos_in   = rd_ff;
               depth_in = depth_ff - DW'(1);
            end
            fdsm_pkg::OP_SWAP: begin
               tos_in = nos_ff;
               nos_in = tos_ff;
            end
            fdsm_pkg::OP_OVER: begin
               wr_en    = 1'b1;
               nos_in   = tos_ff;
               tos_in   = nos_ff;
               depth_in = depth_ff + DW'(1);
            end
            fdsm_pkg::OP_DUP: begin
               wr_en    = (depth_ff >= DW'(2));
               nos_in   = tos_ff;
               depth_in = depth_ff + DW'(1);
            end
            fdsm_pkg::OP_NIP: begin
               nos_in   = rd_ff;
               depth_in = depth_ff - DW'(1);
            end
            fdsm_pkg::OP_ROT: begin
               wr_en   = 1'b1;
               wr_addr = AW'(depth_ff - DW'(3));
               nos_in  = tos_ff;
               tos_in  = rd_ff;
            end
            default: begin
               wr_en = 1'b0;
            end
         endcase
      end

      // Build the response word from the new state
      if (under) begin
         rsp_in.status = fdsm_pkg::ST_UNDER;
      end else if (over) begin
         rsp_in.status = fdsm_pkg::ST_OVER;
      end else begin
         rsp_in.status = fdsm_pkg::ST_OK;
      end
      rsp_in.top_cell    = (depth_in != '0) ? tos_in : '0;
      rsp_in.stack_depth = fdsm_pkg::DEPTH_W'(depth_in);
   end

   // Capture the request and read the third cell; write back on commit
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_word.opcode;
         val_ff <= req_word.push_value;
         rd_ff  <= mem[rd_addr];
      end
      if (cmd.commit && wr_en) begin
         mem[wr_addr] <= nos_ff;
      end
      if (cmd.commit) begin
         tos_ff <= tos_in;
         nos_ff <= nos_in;
         rsp_ff <= rsp_in;
      end
   end

   // Hold the depth count
   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
      end else if (cmd.commit) begin
         depth_ff <= depth_in;
      end
   end

   assign rsp_word = rsp_ff;

endmodule

// ----- src/forth_data_stack_manipulator_core.sv -----
// Forth data stack of STACK_CELLS signed 32-bit cells. Each request word carries
// one opcode (push, DROP, SWAP, OVER, DUP, NIP, ROT) and yields one response word
// with the status, the new top cell (zero when empty) and the depth. Too few cells
// empties the stack and reports underflow; push, DUP or OVER on a full stack
// reports overflow and leaves it unchanged. A word is first captured, reading the
// third cell from the cell memory, whose read data is registered; it then
// executes, writes back and loads the response register, waiting while that
// register holds a response not yet taken. The next request is taken while a
// response still waits to be taken. No clearing pass runs after reset.
module forth_data_stack_manipulator_core #(
   parameter int unsigned STACK_CELLS = 64
) (
   input logic          clock,
   input logic          reset,
   fdsm_stream_if.sink   req_chan,
   fdsm_stream_if.source rsp_chan
);

   fdsm_pkg::cmd_type      cmd;
   fdsm_pkg::req_word_type req_word;
   fdsm_pkg::rsp_word_type rsp_word;

   assign req_word         = req_chan.payload;
   assign rsp_chan.payload = rsp_word;

   fdsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   fdsm_datapath #(
      .STACK_CELLS (STACK_CELLS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_word (req_word),
      .rsp_word (rsp_word)
   );

`ifndef ASSERT_OFF
   // Capture and commit never happen in the same cycle
   a_load_commit_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load && cmd.commit))
      else $error("load and commit in the same cycle");

   // A captured word keeps the input closed for its execute cycle
   a_busy_after_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> !req_chan.ready)
      else $error("request taken while a word is executing");

   // Underflow always leaves an empty stack
   a_under_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.payload.status == fdsm_pkg::ST_UNDER) |->
      (rsp_chan.payload.stack_depth == '0 && rsp_chan.payload.top_cell == '0))
      else $error("underflow response with a non-empty stack");

   // Overflow is only reported on a full stack
   a_over_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.payload.status == fdsm_pkg::ST_OVER) |->
      (rsp_chan.payload.stack_depth == fdsm_pkg::DEPTH_W'(STACK_CELLS)))
      else $error("overflow response below full depth");
`endif

endmodule
